@@ sv/pbis_pkg.sv @@
// Shared types and constants for the pulse burst indicator sequencer.
// Used by every module of the block; no dependencies.
package pbis_pkg;

    // Field widths
    localparam int COUNT_W = 8;
    localparam int TIME_W  = 16;
    localparam int NODE_W  = 8;
    localparam int PHASE_W = 2;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;

    // Item kinds carried in the mode field
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_REQ  = 1'b1;

    // Phase codes
    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_ON   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_GAP  = 2'd2;
    localparam logic [PHASE_W-1:0] PH_POST = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FLASH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP   = 4'd1;

    // Reset values
    localparam logic [TIME_W-1:0] FLASH_RST = 16'd100;
    localparam logic [TIME_W-1:0] GAP_RST   = 16'd100;
    localparam logic [NODE_W-1:0] NO_NODE   = 8'hFF;

    // One input item
    typedef struct packed {
        logic               mode;
        logic [COUNT_W-1:0] pulse_count;
        logic [TIME_W-1:0]  post_hold;
        logic               store_node;
        logic [NODE_W-1:0]  node_number;
    } item_t;

    // One result item
    typedef struct packed {
        logic               indicator_on;
        logic               busy_res;
        logic [NODE_W-1:0]  last_node;
        logic [PHASE_W-1:0] phase;
    } result_t;

endpackage

@@ sv/pulse_burst_indicator_sequencer_core.sv @@
// Pulse burst indicator sequencer, top level.
// Depends on pbis_pkg, pbis_in_stage and pbis_engine.
//
// Every item (a one-millisecond tick or a pulse request) gives exactly one
// result. The block takes one item per clock cycle while no stall holds it.
// An accepted item is held in the input register and moves into the result
// register when that is free; its result then stays on the outputs until it
// is taken. A stalled result holds the input register and stalls the input
// in the same cycle. The burst state is updated once per taken item, so a
// following item sees it at once. The user is to write flash and gap times
// through the configuration port only while the block is idle; the block
// does not enforce this. A new time takes effect the next time a phase is loaded.
module pulse_burst_indicator_sequencer_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [pbis_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pbis_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               mode,
    input  logic [pbis_pkg::COUNT_W-1:0]       pulse_count,
    input  logic [pbis_pkg::TIME_W-1:0]        post_hold,
    input  logic                               store_node,
    input  logic [pbis_pkg::NODE_W-1:0]        node_number,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               indicator_on,
    output logic                               busy_res,
    output logic [pbis_pkg::NODE_W-1:0]        last_node,
    output logic [pbis_pkg::PHASE_W-1:0]       phase
);

    pbis_pkg::item_t   in_item;
    pbis_pkg::item_t   item;
    pbis_pkg::result_t result;
    logic              item_valid;
    logic              take;

    assign in_item.mode          = mode;
    assign in_item.pulse_count   = pulse_count;
    assign in_item.post_hold     = post_hold;
    assign in_item.store_node    = store_node;
    assign in_item.node_number   = node_number;

    pbis_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    pbis_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result     (result)
    );

    assign indicator_on = result.indicator_on;
    assign busy_res     = result.busy_res;
    assign last_node    = result.last_node;
    assign phase        = result.phase;

endmodule

@@ sv/pbis_in_stage.sv @@
// Input register of the sequencer: captures one item per cycle while not stalled.
// Depends on pbis_pkg for the item type.
module pbis_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  pbis_pkg::item_t in_item,
    input  logic           take,
    output logic           item_valid,
    output pbis_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    pbis_pkg::item_t item_reg;
    logic            load;

    // Hold only while the held item cannot move on
    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take || !valid_reg)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ sv/pbis_engine.sv @@
// Burst state, timing registers, next-state logic and result register.
// Depends on pbis_pkg for codes, widths and item/result types.
module pbis_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [pbis_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pbis_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               item_valid,
    input  pbis_pkg::item_t                    item,
    output logic                               take,
    output logic                               out_valid,
    input  logic                               out_stall,
    output pbis_pkg::result_t                  result
);

    logic [pbis_pkg::TIME_W-1:0]  flash_reg;
    logic [pbis_pkg::TIME_W-1:0]  gap_reg;

    logic [pbis_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [pbis_pkg::COUNT_W-1:0] pulses_reg, pulses_next;
    logic [pbis_pkg::TIME_W-1:0]  held_reg, held_next;
    logic [pbis_pkg::TIME_W-1:0]  cd_reg, cd_next;
    logic [pbis_pkg::NODE_W-1:0]  node_reg, node_next;
    logic                         drive_reg, drive_next;

    logic                         out_valid_reg;
    pbis_pkg::result_t            result_reg;

    // Item moves into the result register when that is free
    assign take = item_valid && (!out_valid_reg || !out_stall);

    // Timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flash_reg <= pbis_pkg::FLASH_RST;
            gap_reg   <= pbis_pkg::GAP_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                pbis_pkg::REG_FLASH: flash_reg <= cfg_data;
                pbis_pkg::REG_GAP:   gap_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Next burst state for the held item
    always_comb
    begin
        phase_next  = phase_reg;
        pulses_next = pulses_reg;
        held_next   = held_reg;
        cd_next     = cd_reg;
        node_next   = node_reg;
        drive_next  = drive_reg;
        if (item.mode == pbis_pkg::MODE_REQ)
        begin
            if (item.store_node)
            begin
                node_next = item.node_number;
            end
            if (item.pulse_count != '0)
            begin
                pulses_next = item.pulse_count;
                held_next   = item.post_hold;
                drive_next  = 1'b1;
                phase_next  = pbis_pkg::PH_ON;
                cd_next     = flash_reg;
            end
        end
        else if (phase_reg != pbis_pkg::PH_IDLE)
        begin
            if (cd_reg > pbis_pkg::TIME_W'(1))
            begin
                cd_next = cd_reg - pbis_pkg::TIME_W'(1);
            end
            else
            begin
                // Countdown used up: change phase
                cd_next = '0;
                case (phase_reg)
                    pbis_pkg::PH_ON:
                    begin
                        drive_next = 1'b0;
                        if (pulses_reg != '0)
                        begin
                            pulses_next = pulses_reg - pbis_pkg::COUNT_W'(1);
                        end
                        if (pulses_next != '0)
                        begin
                            phase_next = pbis_pkg::PH_GAP;
                            cd_next    = gap_reg;
                        end
                        else if (held_reg != '0)
                        begin
                            phase_next = pbis_pkg::PH_POST;
                            cd_next    = held_reg;
                        end
                        else
                        begin
                            phase_next = pbis_pkg::PH_IDLE;
                        end
                    end
                    pbis_pkg::PH_GAP:
                    begin
                        drive_next = 1'b1;
                        phase_next = pbis_pkg::PH_ON;
                        cd_next    = flash_reg;
                    end
                    default:
                    begin
                        phase_next = pbis_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Burst state commits once per taken item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= pbis_pkg::PH_IDLE;
            pulses_reg <= '0;
            held_reg   <= '0;
            cd_reg     <= '0;
            node_reg   <= pbis_pkg::NO_NODE;
            drive_reg  <= 1'b0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            pulses_reg <= pulses_next;
            held_reg   <= held_next;
            cd_reg     <= cd_next;
            node_reg   <= node_next;
            drive_reg  <= drive_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg.indicator_on <= drive_next;
            result_reg.busy_res     <= (phase_next != pbis_pkg::PH_IDLE);
            result_reg.last_node    <= node_next;
            result_reg.phase        <= phase_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

@@ sv/pbis_checker.sv @@
// Port-level checks for the pulse burst indicator sequencer, with its bind.
// Depends on pbis_pkg and pulse_burst_indicator_sequencer_core.
module pbis_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic                           indicator_on,
    input logic                           busy_res,
    input logic [pbis_pkg::NODE_W-1:0]    last_node,
    input logic [pbis_pkg::PHASE_W-1:0]   phase
);

    // Busy flag agrees with the phase code
    a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (busy_res == (phase != pbis_pkg::PH_IDLE)))
        else $error("busy_res does not match phase");

    // Indicator is lit only in the on phase
    a_drive_on: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && indicator_on) |-> (phase == pbis_pkg::PH_ON))
        else $error("indicator on outside the on phase");

    // Input backs up only behind a stalled, full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output back-pressure");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(indicator_on)
            && $stable(busy_res) && $stable(last_node) && $stable(phase)))
        else $error("stalled result changed");

endmodule

bind pulse_burst_indicator_sequencer_core pbis_checker u_pbis_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .indicator_on (indicator_on),
    .busy_res     (busy_res),
    .last_node    (last_node),
    .phase        (phase)
);

@@ tb/pulse_burst_indicator_sequencer_core_tb.sv @@
// Self-checking testbench for pulse_burst_indicator_sequencer_core.
// Holds its own model of the burst sequencer and compares every result item.
// Depends on pbis_pkg and the RTL of the block only.
module pulse_burst_indicator_sequencer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 6;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_wr_en = 1'b0;
    logic [pbis_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [pbis_pkg::CFG_DATA_W-1:0]     cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic                                mode = pbis_pkg::MODE_TICK;
    logic [pbis_pkg::COUNT_W-1:0]        pulse_count = '0;
    logic [pbis_pkg::TIME_W-1:0]         post_hold = '0;
    logic                                store_node = 1'b0;
    logic [pbis_pkg::NODE_W-1:0]         node_number = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic                                indicator_on;
    logic                                busy_res;
    logic [pbis_pkg::NODE_W-1:0]         last_node;
    logic [pbis_pkg::PHASE_W-1:0]        phase;

    // Model state of the sequencer, at its reset values
    logic [pbis_pkg::TIME_W-1:0]         flash_ms = pbis_pkg::FLASH_RST;
    logic [pbis_pkg::TIME_W-1:0]         gap_ms = pbis_pkg::GAP_RST;
    logic [pbis_pkg::PHASE_W-1:0]        exp_phase = pbis_pkg::PH_IDLE;
    logic [pbis_pkg::COUNT_W-1:0]        exp_pulses_left = '0;
    logic [pbis_pkg::TIME_W-1:0]         exp_post_hold = '0;
    logic [pbis_pkg::TIME_W-1:0]         exp_countdown = '0;
    logic [pbis_pkg::NODE_W-1:0]         exp_node = pbis_pkg::NO_NODE;
    logic                                exp_lamp = 1'b0;

    pbis_pkg::result_t pending_status[$];
    int      mismatches = 0;
    int      quiet_cycles = 0;
    int      stall_left = 0;
    bit      tx_calm = 1'b0;
    bit      rx_calm = 1'b0;

    pulse_burst_indicator_sequencer_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .pulse_count   (pulse_count),
        .post_hold     (post_hold),
        .store_node    (store_node),
        .node_number   (node_number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .indicator_on  (indicator_on),
        .busy_res      (busy_res),
        .last_node     (last_node),
        .phase         (phase)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly no pause, some short ones, a few long ones
    function automatic int pick_pause(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Advance the burst model by one item and return the status it leaves
    function automatic pbis_pkg::result_t advance_sequencer(pbis_pkg::item_t it);
        pbis_pkg::result_t r;
        if (it.mode == pbis_pkg::MODE_REQ)
        begin
            if (it.store_node)
                exp_node = it.node_number;
            if (it.pulse_count != '0)
            begin
                exp_pulses_left = it.pulse_count;
                exp_post_hold = it.post_hold;
                exp_lamp = 1'b1;
                exp_phase = pbis_pkg::PH_ON;
                exp_countdown = flash_ms;
            end
        end
        else if (exp_phase != pbis_pkg::PH_IDLE)
        begin
            if (exp_countdown > pbis_pkg::TIME_W'(1))
                exp_countdown = exp_countdown - pbis_pkg::TIME_W'(1);
            else
            begin
                exp_countdown = '0;
                case (exp_phase)
                    pbis_pkg::PH_ON:
                    begin
                        exp_lamp = 1'b0;
                        if (exp_pulses_left != '0)
                            exp_pulses_left = exp_pulses_left - pbis_pkg::COUNT_W'(1);
                        if (exp_pulses_left != '0)
                        begin
                            exp_phase = pbis_pkg::PH_GAP;
                            exp_countdown = gap_ms;
                        end
                        else if (exp_post_hold != '0)
                        begin
                            exp_phase = pbis_pkg::PH_POST;
                            exp_countdown = exp_post_hold;
                        end
                        else
                            exp_phase = pbis_pkg::PH_IDLE;
                    end
                    pbis_pkg::PH_GAP:
                    begin
                        exp_lamp = 1'b1;
                        exp_phase = pbis_pkg::PH_ON;
                        exp_countdown = flash_ms;
                    end
                    default:
                        exp_phase = pbis_pkg::PH_IDLE;
                endcase
            end
        end
        r.indicator_on = exp_lamp;
        r.busy_res = (exp_phase != pbis_pkg::PH_IDLE);
        r.last_node = exp_node;
        r.phase = exp_phase;
        return r;
    endfunction

    // Tick item; the fields it ignores carry noise
    function automatic pbis_pkg::item_t make_tick();
        pbis_pkg::item_t it;
        it.mode = pbis_pkg::MODE_TICK;
        it.pulse_count = pbis_pkg::COUNT_W'($urandom);
        it.post_hold = pbis_pkg::TIME_W'($urandom);
        it.store_node = 1'($urandom);
        it.node_number = pbis_pkg::NODE_W'($urandom);
        return it;
    endfunction

    function automatic pbis_pkg::item_t make_req(int count, int post, int store, int node);
        pbis_pkg::item_t it;
        it.mode = pbis_pkg::MODE_REQ;
        it.pulse_count = pbis_pkg::COUNT_W'(count);
        it.post_hold = pbis_pkg::TIME_W'(post);
        it.store_node = 1'(store);
        it.node_number = pbis_pkg::NODE_W'(node);
        return it;
    endfunction

    // Send one item; valid stays high afterwards until the next call decides
    task automatic send_item(input pbis_pkg::item_t it);
        int pause;
        pause = pick_pause(tx_calm);
        @(negedge clk);
        if (pause > 0)
        begin
            in_valid <= 1'b0;
            repeat (pause) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= it.mode;
        pulse_count <= it.pulse_count;
        post_hold <= it.post_hold;
        store_node <= it.store_node;
        node_number <= it.node_number;
        do
            @(posedge clk);
        while (in_stall);
        pending_status.push_back(advance_sequencer(it));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(make_tick());
    endtask

    // Stop sending and wait until every result has come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [pbis_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pbis_pkg::CFG_DATA_W-1:0] val);
        wait_drained();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == pbis_pkg::REG_FLASH)
            flash_ms = val;
        else if (idx == pbis_pkg::REG_GAP)
            gap_ms = val;
    endtask

    // Reset timing: idle ticks, zero-count requests, a restart during a burst
    task automatic test_reset_timing();
        send_item(make_tick());
        send_item(make_req(0, 'h1234, 1, 'h00));
        send_item(make_req(0, 0, 0, 'h55));
        send_item(make_req(1, 0, 1, 'hFF));
        send_ticks(3);
        send_item(make_req(255, 'hFFFF, 0, 'h81));
        send_item(make_req(255, 'hFFFF, 1, 'h7E));
        send_item(make_tick());
        // new times while the on phase runs: the countdown keeps going
        write_reg(pbis_pkg::REG_FLASH, 16'd0);
        write_reg(pbis_pkg::REG_GAP, 16'd1);
        send_item(make_tick());
    endtask

    // Zero and one tick phases, with and without a post delay
    task automatic test_short_phases();
        send_item(make_req(2, 2, 1, 'hAA));
        send_ticks(7);
        send_item(make_req(1, 0, 0, 'h11));
        send_ticks(2);
    endtask

    // Writes to indexes past the last register change nothing
    task automatic test_unused_indexes();
        write_reg(4'd2, 16'hFFFF);
        write_reg(4'd7, 16'h5A5A);
        write_reg(4'd8, 16'hA5A5);
        write_reg(4'd15, 16'hFFFF);
        send_item(make_req(1, 1, 1, 'h3C));
        send_ticks(3);
    endtask

    // Random requests and ticks over a range of flash and gap times
    task automatic test_random_bursts();
        logic [pbis_pkg::TIME_W-1:0] flash_set[10];
        logic [pbis_pkg::TIME_W-1:0] gap_set[10];
        int r;
        int count;
        int post;
        flash_set = '{16'd0, 16'd1, 16'd2, 16'd0, 16'd5, 16'hFFFF, 16'd1, 16'hFFFF,
                      16'd3, 16'd1};
        gap_set = '{16'd0, 16'd1, 16'd3, 16'd4, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0,
                    16'd2, 16'd2};
        flash_set[8] = pbis_pkg::TIME_W'($urandom_range(0, 8));
        gap_set[8] = pbis_pkg::TIME_W'($urandom_range(0, 8));
        for (int s = 0; s < 10; s++)
        begin
            write_reg(pbis_pkg::REG_FLASH, flash_set[s]);
            write_reg(pbis_pkg::REG_GAP, gap_set[s]);
            for (int n = 0; n < 85; n++)
            begin
                if (n % 40 == 0)
                begin
                    tx_calm = ($urandom_range(0, 3) == 0);
                    rx_calm = ($urandom_range(0, 3) == 0);
                end
                r = $urandom_range(0, 99);
                if (r < 80)
                    send_item(make_tick());
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 10)
                        count = 0;
                    else if (r < 85)
                        count = $urandom_range(1, 4);
                    else
                        count = $urandom_range(0, 255);
                    r = $urandom_range(0, 99);
                    if (r < 50)
                        post = 0;
                    else if (r < 90)
                        post = $urandom_range(1, 6);
                    else
                        post = $urandom_range(0, 65535);
                    send_item(make_req(count, post, $urandom_range(0, 1),
                                       $urandom_range(0, 255)));
                end
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // Result side stall pattern
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_left <= pick_pause(rx_calm);
            out_stall <= 1'b0;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: on=%0b busy=%0b node=%0d phase=%0d",
                             indicator_on, busy_res, last_node, phase);
            end
            else
            begin
                pbis_pkg::result_t want;
                want = pending_status.pop_front();
                if (indicator_on !== want.indicator_on || busy_res !== want.busy_res ||
                    last_node !== want.last_node || phase !== want.phase)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $write("mismatch: expected on=%0b busy=%0b node=%0d phase=%0d, ",
                               want.indicator_on, want.busy_res, want.last_node,
                               want.phase);
                        $display("got on=%0b busy=%0b node=%0d phase=%0d",
                                 indicator_on, busy_res, last_node, phase);
                    end
                end
            end
        end
    end

    // Watchdog on cycles where neither side moves an item
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("pulse_burst_indicator_sequencer_core regression: fail");
            $finish;
        end
    end

    // Test sequence
    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_timing();
        test_short_phases();
        test_unused_indexes();
        test_random_bursts();
        wait_drained();
        if (mismatches == 0)
            $display("pulse_burst_indicator_sequencer_core regression: pass");
        else
            $display("pulse_burst_indicator_sequencer_core regression: fail");
        $finish;
    end

endmodule
